// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset
`define CUA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define CUA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/cua_pkg.sv =====
// Package: shared constants and controller/datapath interface types for the allocator
`timescale 1ns / 1ps
`default_nettype none

package cua_pkg;

  localparam int ID_W    = 16;
  localparam int SIZE_W  = 11;
  localparam int START_W = 10;
  localparam int POL_W   = 2;

  // Placement policy codes; any other code selects best fit
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_WORST = 2'd1;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd2;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // latch the incoming transaction
    logic init_wr;    // write zero at the sweep address
    logic dispatch;   // reset search state and preset the result
    logic rd_en;      // read the owner map at the sweep address
    logic scan;       // read data feeds the run tracker
    logic free;       // read data feeds the owner clear
    logic eval_tail;  // evaluate the run still open at the map end
    logic choose;     // settle the result and load the stamp run
    logic wr_run;     // stamp one unit with the owner
    logic finish;     // move the result into the output register
  } cua_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic addr_last;
    logic req_clear;
    logic owner_zero;
    logic size_zero;
    logic fit_ok;
    logic wr_last;
    logic out_busy;
  } cua_stat_t;

endpackage

`default_nettype wire

// ===== sv/cua_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module cua_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cua_ctrl.sv =====
// Controller: sequences the init sweep, map scan, run stamping, owner clear and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module cua_ctrl import cua_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire cua_stat_t stat,
  output      cua_cmd_t  cmd
);

`include "assert_macros.svh"

  localparam logic [3:0] S_INIT       = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_DISPATCH   = 4'd2;
  localparam logic [3:0] S_SCAN       = 4'd3;
  localparam logic [3:0] S_SCAN_DRAIN = 4'd4;
  localparam logic [3:0] S_EVAL       = 4'd5;
  localparam logic [3:0] S_CHOOSE     = 4'd6;
  localparam logic [3:0] S_WRITE      = 4'd7;
  localparam logic [3:0] S_FREE       = 4'd8;
  localparam logic [3:0] S_FREE_DRAIN = 4'd9;
  localparam logic [3:0] S_DONE       = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (stat.req_clear) begin
          state_nxt = stat.owner_zero ? S_DONE : S_FREE;
        end else if (stat.owner_zero || stat.size_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.scan  = 1'b1;
        if (stat.addr_last) begin
          state_nxt = S_SCAN_DRAIN;
        end
      end
      S_SCAN_DRAIN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval_tail = 1'b1;
        state_nxt     = S_CHOOSE;
      end
      S_CHOOSE: begin
        cmd.choose = 1'b1;
        state_nxt  = stat.fit_ok ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        cmd.wr_run = 1'b1;
        if (stat.wr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        cmd.rd_en = 1'b1;
        cmd.free  = 1'b1;
        if (stat.addr_last) begin
          state_nxt = S_FREE_DRAIN;
        end
      end
      S_FREE_DRAIN: begin
        cmd.free  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register can take the result
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CUA_ASSERT(a_accept_dispatch, (in_valid && in_ready) |=> (state_r == S_DISPATCH), "accepted transaction not dispatched")
  `CUA_ASSERT(a_port_excl, $onehot0({cmd.init_wr, cmd.rd_en, cmd.wr_run, cmd.finish}), "conflicting memory commands")
  `CUA_ASSERT_IMPLY(a_write_fit, (state_r == S_WRITE), !stat.req_clear, "stamping during a clear request")

endmodule

`default_nettype wire

// ===== sv/cua_dp.sv =====
// Datapath: request registers, sweep address, free-run tracker, policy choice and result registers
`timescale 1ns / 1ps
`default_nettype none

module cua_dp import cua_pkg::*; #(
  parameter int UNITS      = 1024,
  parameter int OWNER_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cua_cmd_t                 cmd,
  output      cua_stat_t                stat,
  input  wire logic                     in_req_type,
  input  wire logic [ID_W-1:0]          in_owner_id,
  input  wire logic [SIZE_W-1:0]        in_block_size,
  input  wire logic                     cfg_valid,
  input  wire logic [POL_W-1:0]         cfg_fit_policy,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic                     out_status,
  output      logic [START_W-1:0]       out_start_unit,
  output      logic                     mem_we,
  output      logic [$clog2(UNITS)-1:0] mem_waddr,
  output      logic [OWNER_BITS-1:0]    mem_wdata,
  output      logic                     mem_re,
  output      logic [$clog2(UNITS)-1:0] mem_raddr,
  input  wire logic [OWNER_BITS-1:0]    mem_rdata
);

`include "assert_macros.svh"

  localparam int ADDR_W = $clog2(UNITS);
  localparam int LEN_W  = $clog2(UNITS + 1);
  localparam int CMP_W  = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
  localparam int EXT_W  = (ADDR_W > START_W) ? ADDR_W : START_W;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(UNITS - 1);

  // Policy register
  logic [POL_W-1:0] policy_r;

  // Request registers
  logic                  req_clear_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [SIZE_W-1:0]     size_r;

  // Sweep address and stamp counter
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] rem_r;
  logic              rd_pend_r;
  logic [ADDR_W-1:0] rd_idx_r;

  // Run tracker and best candidate
  logic [ADDR_W-1:0] cur_start_r;
  logic [LEN_W-1:0]  cur_len_r;
  logic              found_r;
  logic [ADDR_W-1:0] best_start_r;
  logic [LEN_W-1:0]  best_len_r;

  // Pending result and output register
  logic               res_fail_r;
  logic [START_W-1:0] res_start_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [START_W-1:0] out_start_r;

  logic [ID_W+OWNER_BITS-1:0] owner_ext;
  logic                       unit_free;
  logic                       free_hit;
  logic                       close_run;
  logic                       len_ge;
  logic                       upd;
  logic                       fit_ok;
  logic [EXT_W-1:0]           best_ext;

  assign owner_ext = {{OWNER_BITS{1'b0}}, in_owner_id};
  assign unit_free = (mem_rdata == '0);
  assign free_hit  = cmd.free && rd_pend_r && (mem_rdata == owner_r);
  assign close_run = (cmd.scan && rd_pend_r && !unit_free && (cur_len_r != '0))
                  || (cmd.eval_tail && (cur_len_r != '0));
  assign len_ge    = CMP_W'(cur_len_r) >= CMP_W'(size_r);
  assign fit_ok    = found_r && (CMP_W'(best_len_r) >= CMP_W'(size_r));
  assign best_ext  = EXT_W'(best_start_r);

  // Policy decision for a closed run; ties keep the earlier run
  always_comb begin
    case (policy_r)
      POL_FIRST: upd = len_ge && !found_r;
      POL_WORST: upd = cur_len_r > best_len_r;
      default:   upd = len_ge && (!found_r || (cur_len_r < best_len_r));
    endcase
  end

  // Memory port steering
  assign mem_we    = cmd.init_wr || cmd.wr_run || free_hit;
  assign mem_waddr = free_hit ? rd_idx_r : addr_r;
  assign mem_wdata = cmd.wr_run ? owner_r : '0;
  assign mem_re    = cmd.rd_en;
  assign mem_raddr = addr_r;

  // Status to the controller
  always_comb begin
    stat            = '0;
    stat.addr_last  = (addr_r == ADDR_LAST);
    stat.req_clear  = (req_clear_r == REQ_CLEAR);
    stat.owner_zero = (owner_r == '0);
    stat.size_zero  = (size_r == '0);
    stat.fit_ok     = fit_ok;
    stat.wr_last    = (rem_r == SIZE_W'(1));
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_BEST;
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        policy_r <= cfg_fit_policy;
      end
      // Clear, load or advance the sweep address
      if (cmd.dispatch) begin
        addr_r <= '0;
      end else if (cmd.choose) begin
        addr_r <= best_start_r;
      end else if (cmd.init_wr || cmd.rd_en || cmd.wr_run) begin
        addr_r <= addr_r + ADDR_W'(1);
      end
      rd_pend_r <= cmd.rd_en;
      // Hold the result until the transaction completes
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_clear_r <= in_req_type;
      owner_r     <= owner_ext[OWNER_BITS-1:0];
      size_r      <= in_block_size;
    end
    rd_idx_r <= addr_r;

    // Track the current free run
    if (cmd.dispatch) begin
      cur_len_r <= '0;
    end else if (cmd.scan && rd_pend_r) begin
      if (unit_free) begin
        if (cur_len_r == '0) begin
          cur_start_r <= rd_idx_r;
        end
        cur_len_r <= cur_len_r + LEN_W'(1);
      end else begin
        cur_len_r <= '0;
      end
    end

    // Keep the best candidate run
    if (cmd.dispatch) begin
      found_r    <= 1'b0;
      best_len_r <= '0;
    end else if (close_run && upd) begin
      found_r      <= 1'b1;
      best_len_r   <= cur_len_r;
      best_start_r <= cur_start_r;
    end

    // Count down the stamp run
    if (cmd.choose) begin
      rem_r <= size_r;
    end else if (cmd.wr_run) begin
      rem_r <= rem_r - SIZE_W'(1);
    end

    // Settle the pending result
    if (cmd.dispatch) begin
      res_fail_r  <= (req_clear_r != REQ_CLEAR) && ((owner_r == '0) || (size_r == '0));
      res_start_r <= '0;
    end else if (cmd.choose) begin
      res_fail_r  <= !fit_ok;
      res_start_r <= fit_ok ? best_ext[START_W-1:0] : '0;
    end

    if (cmd.finish) begin
      out_status_r <= res_fail_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_unit = out_start_r;

  `CUA_ASSERT(a_out_rise, $rose(out_valid_r) |-> $past(cmd.finish), "result shown without finish")
  `CUA_ASSERT_IMPLY(a_stamp_count, cmd.wr_run, rem_r != '0, "stamp run past its size")
  `CUA_ASSERT_IMPLY(a_no_overwrite, cmd.finish, !out_valid_r || out_ready, "result register overwritten")

endmodule

`default_nettype wire

// ===== sv/contiguous_unit_allocator_top.sv =====
// Top level: contiguous unit allocator with first, worst and best fit placement
//
// Keeps an owner map of UNITS units in one RAM (zero = free). After reset the block
// sweeps the map to zero with in_ready low; configuration writes are taken at any
// time. An allocate transaction scans every unit once through the RAM's single read
// port, then stamps the granted run one unit per cycle through the write port. A
// clear transaction reads and frees the map in one pass. Allocate requests with a
// zero owner or zero size are rejected without a scan; a clear request with a zero
// owner finishes without a pass. One request is in work at a time; the result sits
// in an output register, so a new request is taken while the previous result still
// waits.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_unit_allocator_top import cua_pkg::*; #(
  parameter int UNITS      = 1024,
  parameter int OWNER_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_req_type,
  input  wire logic [ID_W-1:0]    in_owner_id,
  input  wire logic [SIZE_W-1:0]  in_block_size,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               out_status,
  output      logic [START_W-1:0] out_start_unit,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [POL_W-1:0]   cfg_fit_policy
);

  localparam int ADDR_W = $clog2(UNITS);

  cua_cmd_t              cmd;
  cua_stat_t             stat;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [OWNER_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [OWNER_BITS-1:0] mem_rdata;

  // The policy register takes a write in any cycle
  assign cfg_ready = 1'b1;

  cua_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cua_dp #(
    .UNITS      (UNITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_owner_id    (in_owner_id),
    .in_block_size  (in_block_size),
    .cfg_valid      (cfg_valid),
    .cfg_fit_policy (cfg_fit_policy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_start_unit (out_start_unit),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  cua_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (UNITS)
  ) u_owner_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
